// ===== rtl/bwp_pkg.sv =====
// Package for the burst waveform player: codes, state encoding and widths for
// the RTL modules, and the scaling and saturation helpers of the top level.
// No dependencies.
package bwp_pkg;

   localparam int TIME_W   = 48;
   localparam int CYCLE_W  = 32;
   localparam int COUNT_W  = 16;
   localparam int LEVEL_W  = 16;
   localparam int SIZE_W   = 15;
   localparam int CSR_W    = 48;
   localparam int CSR_IDX_W = 3;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_START = 2'd1,
      OP_TICK  = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      REGION_LEAD  = 2'd0,
      REGION_BURST = 2'd1,
      REGION_PAUSE = 2'd2,
      REGION_DONE  = 2'd3
   } region_type;

   localparam logic [CSR_IDX_W-1:0] CSR_CYCLE_LENGTH     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CYCLES_PER_BURST = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD_LENGTH    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BURST_REPS       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_AMPLITUDE        = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_LEVEL_OFFSET     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_TABLE_SIZE       = 3'd6;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_HOLD_MUL,
      ST_HOLD_SAT,
      ST_TICK,
      ST_PERIOD,
      ST_LOOP,
      ST_DIV_PHASE,
      ST_MUL_N,
      ST_DIV_INDEX,
      ST_READ,
      ST_MUL_AMP,
      ST_SCALE,
      ST_OUT
   } state_type;

   // Divider handshake seen by the sequencer.
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   // Rounds a Q2.30 product to Q1.15: add half an LSB, then floor.
   function automatic logic signed [18:0] scale_round(input logic signed [32:0] p);
      logic signed [33:0] s;
      s = 34'(p) + 34'sd16384;
      return s[33:15];
   endfunction

   function automatic logic signed [15:0] sat16(input logic signed [18:0] v);
      if (v > 19'sd32767) begin
         return 16'sh7fff;
      end else if (v < -19'sd32768) begin
         return 16'sh8000;
      end
      return v[15:0];
   endfunction

endpackage

// ===== rtl/burst_waveform_player.sv =====
// Burst waveform player top level: sequencer, configuration registers and
// result register. Uses bwp_pkg, bwp_ram and bwp_div.
//
//   channel | direction | handshake               | payload
//   req_    | in        | req_valid / req_stall   | operation, table and start fields
//   rsp_    | out       | rsp_valid / rsp_stall   | sample, region
//   csr_    | in        | csr_we                  | csr_index, csr_wdata
//
// A load item or a plain start item leaves the block idle, so the next item
// can follow at once; a start item that takes the hold level from the table
// first passes through a RAM read, a multiply and a round. A lead-in tick
// passes the tick and output states, a pause or finished tick also the period
// and loop states. A burst tick adds two passes of the serial divider (phase,
// then index), a RAM read, the gain multiply and the scaling; each repetition
// passed over inside one tick adds one more pass through the loop state.
// Reset is synchronous; it loads the configuration defaults and clears the
// player state and the result valid flag; the table contents are not cleared.
// The block takes a new item while a result waits; it stalls at the end of a
// tick only until the result register is free.

module burst_waveform_player
   import bwp_pkg::*;
#(
   parameter int TABLE_DEPTH = 16384
) (
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_operation,
   input  logic [13:0]           req_table_address,
   input  logic signed [15:0]    req_table_value,
   input  logic [15:0]           req_start_delay,
   input  logic signed [15:0]    req_init_level,
   input  logic signed [15:0]    req_hold_level,
   input  logic                  req_hold_last_sample,

   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic signed [15:0]    rsp_sample,
   output logic [1:0]            rsp_region,

   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_W-1:0]      csr_wdata
);

   localparam int ADDR_W = $clog2(TABLE_DEPTH);

   // Configuration registers.
   logic [CYCLE_W-1:0]         cycle_length_ff, cycle_length_in;
   logic [COUNT_W-1:0]         cycles_per_burst_ff, cycles_per_burst_in;
   logic [TIME_W-1:0]          period_length_ff, period_length_in;
   logic [COUNT_W-1:0]         burst_reps_ff, burst_reps_in;
   logic [15:0]                amplitude_ff, amplitude_in;
   logic signed [LEVEL_W-1:0]  level_offset_ff, level_offset_in;
   logic [SIZE_W-1:0]          table_size_ff, table_size_in;

   // Player state.
   state_type                  state_ff, state_in;
   logic [TIME_W-1:0]          elapsed_ff, elapsed_in;
   logic [COUNT_W-1:0]         rep_count_ff, rep_count_in;
   logic [COUNT_W-1:0]         delay_left_ff, delay_left_in;
   logic signed [LEVEL_W-1:0]  lead_level_ff, lead_level_in;
   logic signed [LEVEL_W-1:0]  pause_level_ff, pause_level_in;
   logic                       armed_ff, armed_in;

   // Working registers of one tick.
   logic [TIME_W-1:0]          burst_ff, burst_in;
   logic [TIME_W-1:0]          period_ff, period_in;
   logic [TIME_W-1:0]          prod_n_ff, prod_n_in;
   logic signed [32:0]         prod_ff, prod_in;
   logic signed [LEVEL_W-1:0]  level_ff, level_in;
   region_type                 region_ff, region_in;

   // Result register.
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [LEVEL_W-1:0]  rsp_sample_ff, rsp_sample_in;
   region_type                 rsp_region_ff, rsp_region_in;

   // Shared units and helpers.
   logic                       accept;
   op_type                     op;
   logic [CYCLE_W-1:0]         cl;
   logic [SIZE_W-1:0]          used_n;
   logic [ADDR_W-1:0]          last_idx;
   logic                       ram_we;
   logic [ADDR_W-1:0]          ram_raddr;
   logic signed [LEVEL_W-1:0]  ram_rdata;
   logic signed [32:0]         amp_prod;
   logic                       div_start;
   logic [TIME_W-1:0]          div_dividend;
   logic [TIME_W-1:0]          div_quo;
   logic [CYCLE_W-1:0]         div_rem;
   div_status_type             div_stat;
   logic [TIME_W:0]            elapsed_step;
   logic [TIME_W-1:0]          elapsed_adv;
   logic signed [LEVEL_W-1:0]  pause_out;

   assign accept = req_valid && !req_stall;
   assign op     = op_type'(req_operation);
   assign req_stall = (state_ff != ST_IDLE);

   // A zero cycle length acts as one; the table size is clamped to 1..depth.
   assign cl = (cycle_length_ff == '0) ? CYCLE_W'(1) : cycle_length_ff;
   assign used_n = (table_size_ff == '0) ? SIZE_W'(1) :
                   (32'(table_size_ff) > TABLE_DEPTH) ? SIZE_W'(TABLE_DEPTH) : table_size_ff;
   assign last_idx = ADDR_W'(used_n - SIZE_W'(1));

   // The table write is dropped for an address beyond the table.
   assign ram_we = accept && (op == OP_LOAD) && (32'(req_table_address) < TABLE_DEPTH);
   assign ram_raddr = (state_ff == ST_IDLE) ? last_idx : ADDR_W'(div_quo);

   bwp_ram #(
      .WIDTH (LEVEL_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ADDR_W'(req_table_address)),
      .wr_data (req_table_value),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // The one gain multiplier serves both the hold level and burst samples.
   assign amp_prod = 33'(ram_rdata) * $signed({1'b0, amplitude_ff});

   bwp_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (cl),
      .quotient  (div_quo),
      .remainder (div_rem),
      .status    (div_stat)
   );

   // A burst or pause tick moves time by one point, saturating at the top of the range.
   assign elapsed_step = {1'b0, elapsed_ff} + (TIME_W+1)'(65536);
   assign elapsed_adv  = elapsed_step[TIME_W] ? '1 : elapsed_step[TIME_W-1:0];
   assign pause_out    = sat16(19'(pause_level_ff) + 19'(level_offset_ff));

   // Configuration writes.
   always_comb begin
      cycle_length_in     = cycle_length_ff;
      cycles_per_burst_in = cycles_per_burst_ff;
      period_length_in    = period_length_ff;
      burst_reps_in       = burst_reps_ff;
      amplitude_in        = amplitude_ff;
      level_offset_in     = level_offset_ff;
      table_size_in       = table_size_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_CYCLE_LENGTH:     cycle_length_in     = csr_wdata[CYCLE_W-1:0];
            CSR_CYCLES_PER_BURST: cycles_per_burst_in = csr_wdata[COUNT_W-1:0];
            CSR_PERIOD_LENGTH:    period_length_in    = csr_wdata[TIME_W-1:0];
            CSR_BURST_REPS:       burst_reps_in       = csr_wdata[COUNT_W-1:0];
            CSR_AMPLITUDE:        amplitude_in        = csr_wdata[15:0];
            CSR_LEVEL_OFFSET:     level_offset_in     = csr_wdata[LEVEL_W-1:0];
            CSR_TABLE_SIZE:       table_size_in       = csr_wdata[SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   // Sequencer: next state and data path controls.
   always_comb begin
      state_in       = state_ff;
      elapsed_in     = elapsed_ff;
      rep_count_in   = rep_count_ff;
      delay_left_in  = delay_left_ff;
      lead_level_in  = lead_level_ff;
      pause_level_in = pause_level_ff;
      armed_in       = armed_ff;
      burst_in       = burst_ff;
      period_in      = period_ff;
      prod_n_in      = prod_n_ff;
      prod_in        = prod_ff;
      level_in       = level_ff;
      region_in      = region_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_sample_in  = rsp_sample_ff;
      rsp_region_in  = rsp_region_ff;
      div_start      = 1'b0;
      div_dividend   = elapsed_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (op)
                  OP_START: begin
                     elapsed_in    = '0;
                     rep_count_in  = '0;
                     delay_left_in = req_start_delay;
                     lead_level_in = req_init_level;
                     armed_in      = 1'b1;
                     if (req_hold_last_sample) begin
                        state_in = ST_HOLD_MUL;
                     end else begin
                        pause_level_in = req_hold_level;
                     end
                  end
                  OP_TICK: state_in = ST_TICK;
                  default: ;
               endcase
            end
         end
         ST_HOLD_MUL: begin
            prod_in  = amp_prod;
            state_in = ST_HOLD_SAT;
         end
         ST_HOLD_SAT: begin
            pause_level_in = sat16(scale_round(prod_ff));
            state_in       = ST_IDLE;
         end
         ST_TICK: begin
            if (armed_ff && delay_left_ff != '0) begin
               delay_left_in = delay_left_ff - 1'b1;
               level_in  = sat16(19'(lead_level_ff) + 19'(level_offset_ff));
               region_in = REGION_LEAD;
               state_in  = ST_OUT;
            end else begin
               burst_in = TIME_W'(cycles_per_burst_ff * cl);
               state_in = ST_PERIOD;
            end
         end
         ST_PERIOD: begin
            period_in = (period_length_ff > burst_ff) ? period_length_ff : burst_ff;
            level_in  = pause_out;
            region_in = REGION_DONE;
            state_in  = ST_LOOP;
         end
         ST_LOOP: begin
            // One repetition is examined per cycle.
            if (!armed_ff || rep_count_ff >= burst_reps_ff) begin
               state_in = ST_OUT;
            end else if (elapsed_ff <= burst_ff) begin
               div_start    = 1'b1;
               div_dividend = elapsed_ff;
               state_in     = ST_DIV_PHASE;
            end else if (elapsed_ff <= period_ff) begin
               region_in  = REGION_PAUSE;
               elapsed_in = elapsed_adv;
               state_in   = ST_OUT;
            end else begin
               rep_count_in = rep_count_ff + 1'b1;
               if (rep_count_in >= burst_reps_ff) begin
                  state_in = ST_OUT;
               end else begin
                  elapsed_in = elapsed_ff - period_ff;
               end
            end
         end
         ST_DIV_PHASE: begin
            if (div_stat.done) begin
               prod_n_in = TIME_W'(div_rem * used_n);
               state_in  = ST_MUL_N;
            end
         end
         ST_MUL_N: begin
            div_start    = 1'b1;
            div_dividend = prod_n_ff;
            state_in     = ST_DIV_INDEX;
         end
         ST_DIV_INDEX: begin
            if (div_stat.done) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_MUL_AMP;
         end
         ST_MUL_AMP: begin
            prod_in  = amp_prod;
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            level_in   = sat16(scale_round(prod_ff) + 19'(level_offset_ff));
            region_in  = REGION_BURST;
            elapsed_in = elapsed_adv;
            state_in   = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = level_ff;
               rsp_region_in = region_ff;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cycle_length_ff     <= CYCLE_W'(65536);
         cycles_per_burst_ff <= COUNT_W'(1);
         period_length_ff    <= '0;
         burst_reps_ff       <= COUNT_W'(1);
         amplitude_ff        <= 16'd32768;
         level_offset_ff     <= '0;
         table_size_ff       <= SIZE_W'(16384);
         state_ff            <= ST_IDLE;
         elapsed_ff          <= '0;
         rep_count_ff        <= '0;
         delay_left_ff       <= '0;
         lead_level_ff       <= '0;
         pause_level_ff      <= '0;
         armed_ff            <= 1'b0;
         rsp_valid_ff        <= 1'b0;
      end else begin
         cycle_length_ff     <= cycle_length_in;
         cycles_per_burst_ff <= cycles_per_burst_in;
         period_length_ff    <= period_length_in;
         burst_reps_ff       <= burst_reps_in;
         amplitude_ff        <= amplitude_in;
         level_offset_ff     <= level_offset_in;
         table_size_ff       <= table_size_in;
         state_ff            <= state_in;
         elapsed_ff          <= elapsed_in;
         rep_count_ff        <= rep_count_in;
         delay_left_ff       <= delay_left_in;
         lead_level_ff       <= lead_level_in;
         pause_level_ff      <= pause_level_in;
         armed_ff            <= armed_in;
         rsp_valid_ff        <= rsp_valid_in;
      end
      burst_ff      <= burst_in;
      period_ff     <= period_in;
      prod_n_ff     <= prod_n_in;
      prod_ff       <= prod_in;
      level_ff      <= level_in;
      region_ff     <= region_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_region_ff <= rsp_region_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_sample = rsp_sample_ff;
   assign rsp_region = rsp_region_ff;

endmodule

// ===== rtl/bwp_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module bwp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16384
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/bwp_div.sv =====
// Restoring serial divider, one quotient bit per cycle, 48-bit dividend by
// 32-bit divisor. Uses bwp_pkg for widths and the status struct.
module bwp_div
   import bwp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [TIME_W-1:0]    dividend,
   input  logic [CYCLE_W-1:0]   divisor,
   output logic [TIME_W-1:0]    quotient,
   output logic [CYCLE_W-1:0]   remainder,
   output div_status_type       status
);

   logic [TIME_W-1:0]          quo_ff, quo_in;
   logic [CYCLE_W-1:0]         rem_ff, rem_in;
   logic [CYCLE_W-1:0]         den_ff, den_in;
   logic [$clog2(TIME_W)-1:0]  count_ff, count_in;
   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [CYCLE_W:0]           trial;
   logic                       fits;

   always_comb begin
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      trial    = {rem_ff, quo_ff[TIME_W-1]};
      fits     = trial >= {1'b0, den_ff};
      if (start) begin
         quo_in   = dividend;
         rem_in   = '0;
         den_in   = divisor;
         count_in = $clog2(TIME_W)'(TIME_W - 1);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? CYCLE_W'(trial - {1'b0, den_ff}) : trial[CYCLE_W-1:0];
         quo_in = {quo_ff[TIME_W-2:0], fits};
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            count_in = count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign quotient    = quo_ff;
   assign remainder   = rem_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

// ===== sim/tb_burst_waveform_player.sv =====
// Self-checking testbench for burst_waveform_player: directed and random items,
// predicted sample by sample and compared on the result channel.
// Depends on rtl/bwp_pkg.sv and rtl/burst_waveform_player.sv.
module tb_burst_waveform_player;
   import bwp_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH          = 16384;
   localparam int FILL_COUNT     = 64;
   localparam int IDLE_LIMIT     = 20000;
   localparam int RANDOM_PER_SET = 160;
   localparam int SETTING_COUNT  = 8;

   typedef struct {
      op_type             op;
      logic [13:0]        addr;
      logic signed [15:0] value;
      logic [15:0]        delay;
      logic signed [15:0] init_lvl;
      logic signed [15:0] hold_lvl;
      logic               hold_last;
   } player_item_type;

   typedef struct {
      logic signed [15:0] smp;
      region_type         rgn;
   } out_point_type;

   typedef struct {
      player_item_type    it;
      bit                 typed;
      logic signed [15:0] smp;
      region_type         rgn;
   } directed_row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [1:0]           req_operation = OP_NONE;
   logic [13:0]          req_table_address = '0;
   logic signed [15:0]   req_table_value = '0;
   logic [15:0]          req_start_delay = '0;
   logic signed [15:0]   req_init_level = '0;
   logic signed [15:0]   req_hold_level = '0;
   logic                 req_hold_last_sample = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic signed [15:0]   rsp_sample;
   logic [1:0]           rsp_region;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]     csr_wdata = '0;

   burst_waveform_player u_top (.*);

   always #5 clock = ~clock;

   // Shadow copy of the player: configuration, table and sequencing state.
   logic signed [15:0]  wave_copy [DEPTH];
   longint unsigned     cyc_len, period_len, elapsed;
   int unsigned         cyc_per_burst, rep_limit, gain, tsize;
   int unsigned         reps_done, lead_left;
   logic signed [15:0]  offset, lead_lvl, pause_lvl;
   bit                  armed;

   out_point_type expected_points [$];
   int  mismatch_count = 0;
   bit  req_taken, rsp_taken;
   bit  hold_off_wanted = 1'b0;
   bit  hold_off_done = 1'b0;
   bit  no_gaps = 1'b0;

   function automatic logic signed [15:0] clamp16(longint v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return 16'sh8000;
      return v[15:0];
   endfunction

   // Q1.15 gain with round half up, i.e. floor after adding half an LSB.
   function automatic longint gain_scale(logic signed [15:0] v);
      longint p;
      p = longint'(v) * longint'(gain) + 16384;
      return p >>> 15;
   endfunction

   function automatic int unsigned table_span();
      if (tsize == 0) return 1;
      if (tsize > DEPTH) return DEPTH;
      return tsize;
   endfunction

   function automatic void step_time();
      elapsed = elapsed + 64'd65536;
      if (elapsed > 64'hFFFF_FFFF_FFFF) elapsed = 64'hFFFF_FFFF_FFFF;
   endfunction

   // Applies one item to the shadow state; returns 1 with the point it yields.
   function automatic bit play_item(player_item_type it, output out_point_type pt);
      longint unsigned cl, burst, per, ph, idx, n;
      pt.smp = '0;
      pt.rgn = REGION_DONE;
      case (it.op)
         OP_LOAD: begin
            wave_copy[it.addr] = it.value;
            return 1'b0;
         end
         OP_START: begin
            elapsed   = 0;
            reps_done = 0;
            lead_left = it.delay;
            lead_lvl  = it.init_lvl;
            pause_lvl = it.hold_last ? clamp16(gain_scale(wave_copy[table_span() - 1]))
                                     : it.hold_lvl;
            armed     = 1'b1;
            return 1'b0;
         end
         OP_TICK: begin
            if (armed && lead_left > 0) begin
               lead_left--;
               pt.smp = clamp16(longint'(lead_lvl) + longint'(offset));
               pt.rgn = REGION_LEAD;
               return 1'b1;
            end
            cl    = (cyc_len != 0) ? cyc_len : 1;
            burst = longint'(cyc_per_burst) * cl;
            per   = (period_len > burst) ? period_len : burst;
            n     = table_span();
            pt.smp = clamp16(longint'(pause_lvl) + longint'(offset));
            // Short periods may skip several repetitions within one tick.
            while (armed && reps_done < rep_limit) begin
               if (elapsed <= burst) begin
                  ph  = elapsed % cl;
                  idx = ((ph * n) / cl) % n;
                  pt.smp = clamp16(gain_scale(wave_copy[idx]) + longint'(offset));
                  pt.rgn = REGION_BURST;
                  step_time();
                  break;
               end
               if (elapsed <= per) begin
                  pt.rgn = REGION_PAUSE;
                  step_time();
                  break;
               end
               reps_done++;
               if (reps_done >= rep_limit) break;
               elapsed = elapsed - per;
            end
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   function automatic void reset_shadow();
      cyc_len = 65536; cyc_per_burst = 1; period_len = 0; rep_limit = 1;
      gain = 32768; offset = '0; tsize = 16384;
      elapsed = 0; reps_done = 0; lead_left = 0;
      lead_lvl = '0; pause_lvl = '0; armed = 1'b0;
   endfunction

   // Offers one item, waits for it to be taken, then idles a random gap.
   // Stall is read at the falling edge, where it is stable for the next rise.
   task automatic offer(player_item_type it, bit typed = 0,
                        logic signed [15:0] t_smp = '0, region_type t_rgn = REGION_DONE);
      bit            taken;
      out_point_type pt;
      int            gap;
      req_valid            <= 1'b1;
      req_operation        <= it.op;
      req_table_address    <= it.addr;
      req_table_value      <= it.value;
      req_start_delay      <= it.delay;
      req_init_level       <= it.init_lvl;
      req_hold_level       <= it.hold_lvl;
      req_hold_last_sample <= it.hold_last;
      do begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end while (!taken);
      if (play_item(it, pt)) begin
         if (typed) begin
            pt.smp = t_smp;
            pt.rgn = t_rgn;
         end
         expected_points.push_back(pt);
      end
      if (no_gaps) gap = 0;
      else if ($urandom_range(0, 19) == 0) gap = $urandom_range(20, 60);
      else if ($urandom_range(0, 1) == 0) gap = 0;
      else gap = $urandom_range(1, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Lets every expected point come back, then idles on so that a trailing
   // load or start has settled before the registers change.
   task automatic drain();
      req_valid <= 1'b0;
      while (expected_points.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_setting(longint unsigned cl, int unsigned cpb, longint unsigned per,
                                int unsigned reps, int unsigned amp, logic signed [15:0] off,
                                int unsigned ts);
      logic [CSR_W-1:0] vals [7];
      logic [CSR_IDX_W-1:0] idxs [7];
      vals = '{CSR_W'(cl), CSR_W'(cpb), CSR_W'(per), CSR_W'(reps), CSR_W'(amp),
               {{32{off[15]}}, off}, CSR_W'(ts)};
      idxs = '{CSR_CYCLE_LENGTH, CSR_CYCLES_PER_BURST, CSR_PERIOD_LENGTH, CSR_BURST_REPS,
               CSR_AMPLITUDE, CSR_LEVEL_OFFSET, CSR_TABLE_SIZE};
      for (int i = 0; i < 7; i++) begin
         csr_we    <= 1'b1;
         csr_index <= idxs[i];
         csr_wdata <= vals[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      cyc_len = 64'(cl[31:0]); cyc_per_burst = 32'(cpb[15:0]); period_len = 64'(per[47:0]);
      rep_limit = 32'(reps[15:0]); gain = 32'(amp[15:0]); offset = off;
      tsize = 32'(ts[14:0]);
   endtask

   function automatic player_item_type random_item();
      player_item_type it;
      int unsigned     pick;
      it.addr      = 14'($urandom_range(0, DEPTH - 1));
      it.value     = 16'($urandom);
      it.delay     = ($urandom_range(0, 15) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4));
      it.init_lvl  = 16'($urandom);
      it.hold_lvl  = 16'($urandom);
      it.hold_last = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 99);
      if (pick < 80) it.op = OP_TICK;
      else if (pick < 88) it.op = OP_START;
      else if (pick < 96) it.op = OP_LOAD;
      else it.op = OP_NONE;
      return it;
   endfunction

   function automatic player_item_type mk(op_type op, logic [13:0] a, logic signed [15:0] v,
                                          logic [15:0] d, logic signed [15:0] il,
                                          logic signed [15:0] hl, logic h);
      player_item_type it;
      it = '{op, a, v, d, il, hl, h};
      return it;
   endfunction

   // Result side: a point is taken at the rise that follows a falling edge
   // at which valid is high and stall is low.
   always @(negedge clock) begin
      out_point_type want;
      rsp_taken = !reset && rsp_valid && !rsp_stall;
      req_taken = !reset && req_valid && !req_stall;
      if (rsp_taken) begin
         if (expected_points.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected point: sample %0d region %0d", rsp_sample, rsp_region);
         end else begin
            want = expected_points.pop_front();
            if (rsp_sample !== want.smp || rsp_region !== want.rgn) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("point mismatch: expected sample %0d region %0d, got %0d / %0d",
                           want.smp, want.rgn, rsp_sample, rsp_region);
            end
         end
      end
   end

   // Receiver back-pressure: mixed segments of no stall, random stall and long
   // stalls, plus one long hold-off while the sender keeps offering ticks.
   initial begin
      int len, mode;
      @(negedge reset);
      forever begin
         if (hold_off_wanted && !hold_off_done) begin
            rsp_stall <= 1'b1;
            repeat (3000) @(posedge clock);
            hold_off_done = 1'b1;
         end else begin
            mode = $urandom_range(0, 9);
            len  = $urandom_range(1, 40);
            if (mode == 0) begin
               rsp_stall <= 1'b1;
               repeat ($urandom_range(20, 80)) @(posedge clock);
            end else begin
               repeat (len) begin
                  rsp_stall <= (mode < 5) ? 1'b0 : ($urandom_range(0, 1) == 1);
                  @(posedge clock);
               end
            end
         end
      end
   end

   // Watchdog on cycles in which neither channel moves an item.
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if (req_taken || rsp_taken || reset || csr_we) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   initial begin
      directed_row_type rows [$];
      player_item_type  it;
      reset_shadow();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Fill every entry that a tick or a start below can read: the low entries
      // for table sizes up to FILL_COUNT and the last entry of the full table.
      no_gaps = 1'b1;
      for (int a = 0; a < FILL_COUNT; a++)
         offer(mk(OP_LOAD, 14'(a), 16'($urandom), 0, 0, 0, 0));
      offer(mk(OP_LOAD, 14'(DEPTH - 1), 16'($urandom), 0, 0, 0, 0));
      no_gaps = 1'b0;

      // Directed part under the reset configuration: one point per cycle,
      // one cycle per burst, one repetition.
      rows = '{
         // Ticks before any start give the hold level of zero, all reps done.
         '{mk(OP_TICK, 0, 0, 0, 0, 0, 0), 1, 16'sd0, REGION_DONE},
         '{mk(OP_NONE, 14'h3fff, -1, 16'hffff, -1, -1, 1), 0, 0, REGION_DONE},
         '{mk(OP_TICK, 0, 0, 0, 0, 0, 0), 1, 16'sd0, REGION_DONE},
         '{mk(OP_LOAD, 0, 16'sh7fff, 0, 0, 0, 0), 0, 0, REGION_DONE},
         '{mk(OP_LOAD, 14'h3fff, 16'sh8000, 0, 0, 0, 0), 0, 0, REGION_DONE},
         '{mk(OP_LOAD, 1, 16'sd0, 0, 0, 0, 0), 0, 0, REGION_DONE},
         '{mk(OP_START, 0, 0, 16'd2, 16'sh7fff, 16'sh8000, 0), 0, 0, REGION_DONE},
         '{mk(OP_TICK, 0, 0, 0, 0, 0, 0), 1, 16'sh7fff, REGION_LEAD},
         '{mk(OP_TICK, 0, 0, 0, 0, 0, 0), 1, 16'sh7fff, REGION_LEAD},
         '{mk(OP_TICK, 0, 0, 0, 0, 0, 0), 0, 0, REGION_DONE},
         '{mk(OP_TICK, 0, 0, 0, 0, 0, 0), 0, 0, REGION_DONE},
         '{mk(OP_TICK, 0, 0, 0, 0, 0, 0), 1, 16'sh8000, REGION_DONE},
         // Hold level taken from the last table entry.
         '{mk(OP_START, 0, 0, 16'd0, 16'sh8000, 16'sd0, 1), 0, 0, REGION_DONE},
         '{mk(OP_TICK, 0, 0, 0, 0, 0, 0), 0, 0, REGION_DONE},
         '{mk(OP_TICK, 0, 0, 0, 0, 0, 0), 0, 0, REGION_DONE},
         '{mk(OP_TICK, 0, 0, 0, 0, 0, 0), 0, 0, REGION_DONE},
         '{mk(OP_START, 0, 0, 16'hffff, 16'sh8000, 16'sh7fff, 0), 0, 0, REGION_DONE},
         '{mk(OP_TICK, 0, 0, 0, 0, 0, 0), 1, 16'sh8000, REGION_LEAD},
         '{mk(OP_START, 0, 0, 16'd1, 16'sd5, 16'sh7fff, 0), 0, 0, REGION_DONE},
         '{mk(OP_TICK, 0, 0, 0, 0, 0, 0), 1, 16'sd5, REGION_LEAD},
         '{mk(OP_TICK, 0, 0, 0, 0, 0, 0), 0, 0, REGION_DONE},
         '{mk(OP_TICK, 0, 0, 0, 0, 0, 0), 0, 0, REGION_DONE},
         '{mk(OP_TICK, 0, 0, 0, 0, 0, 0), 1, 16'sh7fff, REGION_DONE}
      };
      foreach (rows[i]) offer(rows[i].it, rows[i].typed, rows[i].smp, rows[i].rgn);

      for (int s = 1; s <= SETTING_COUNT; s++) begin
         drain();
         case (s)
            1: write_setting(65536 * 3, 2, 65536 * 10, 3, 32768, 16'sd0, 16);
            // Zero cycle length, zero cycles per burst and zero table size.
            2: write_setting(0, 0, 65536 * 4, 65535, 65535, 16'sh7fff, 0);
            // Largest cycle length, burst, period and table size; no repetitions at all.
            3: write_setting(32'hffff_ffff, 65535, 48'hffff_ffff_ffff, 0, 0, 16'sh8000, 32767);
            4: write_setting(100000, 1, 65536 * 5 + 7, 2, 12345, -16'sd100, FILL_COUNT);
            // Period shorter than one point: repetitions pass inside one tick.
            5: write_setting(65536, 0, 0, 5, 40000, 16'sd300, 8);
            default: write_setting(64'($urandom_range(1, 65536 * 8)), $urandom_range(1, 4),
                                   64'($urandom_range(0, 65536 * 40)), $urandom_range(0, 5),
                                   $urandom_range(0, 65535), 16'($urandom),
                                   $urandom_range(1, FILL_COUNT));
         endcase
         no_gaps = (s % 3 == 0);
         // Arm the player right away so most ticks see a live burst sequence.
         it = random_item();
         it.op = OP_START;
         it.delay = 16'($urandom_range(0, 3));
         offer(it);
         if (s == 1) hold_off_wanted = 1'b1;
         for (int k = 0; k < RANDOM_PER_SET; k++) offer(random_item());
      end

      drain();
      repeat (200) @(posedge clock);
      if (mismatch_count == 0 && expected_points.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ===== burst_waveform_player.f =====
rtl/bwp_pkg.sv
rtl/bwp_ram.sv
rtl/bwp_div.sv
rtl/burst_waveform_player.sv
sim/tb_burst_waveform_player.sv
